/* sv/awsg_pkg.sv */
// Shared types, widths and helpers of the annulus wedge span generator.
// No dependencies; the ROM, the output buffer, the top level and the testbench import this package.
package awsg_pkg;

  localparam int unsigned DEF_TABLE_POINTS = 1024;

  localparam int unsigned ROW_W   = 9;
  localparam int unsigned RAD_W   = 12;
  localparam int unsigned RAY_W   = 16;
  localparam int unsigned A_W     = 12;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned ROM_W   = 17;
  localparam int unsigned PROD_W  = 27;
  localparam int unsigned RAY_QB  = 27;
  localparam int unsigned BOUND_W = 28;
  localparam int unsigned HW_W    = 12;
  localparam int unsigned XS_W    = 18;
  localparam int unsigned SROW_W  = 14;
  localparam int unsigned SPW_W   = 14;
  localparam int unsigned CFG_W   = 12;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // Register select taken from address bit 2.
  localparam logic REG_CENTER_X = 1'b0;
  localparam logic REG_CENTER_Y = 1'b1;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  typedef struct packed {
    logic signed [XS_W-1:0]   x_start;
    logic signed [SROW_W-1:0] screen_row;
    logic [SPW_W-1:0]         span_width;
    logic                     last;
  } span_t;

  typedef struct packed {
    logic neg;    // floored quotient is negative
    logic upper;  // bound limits x from above
    logic szero;  // sine is zero, no bound
    logic rejz;   // zero sine rejects the row
  } ray_side_t;

  typedef struct packed {
    logic signed [ROW_W-1:0] y;
    logic [RAD_W-1:0]        rin;
    logic [RAD_W-1:0]        rout;
    logic                    zout;
    logic                    zin;
    logic                    inner;
    logic                    wedge;
    ray_side_t               r1;
    ray_side_t               r2;
  } side_t;

  function automatic logic [RAY_W-1:0] mag16(logic signed [RAY_W-1:0] v);
    return v[RAY_W-1] ? RAY_W'(-v) : RAY_W'(v);
  endfunction

endpackage

/* sv/awsg_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing but the clock enable handed down by the top level.
module awsg_div_pipe #(
  parameter int unsigned DW = 12,
  parameter int unsigned QB = 27
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [QB+DW-1:0] num_i,
  input  logic [DW-1:0]    den_i,
  output logic [QB-1:0]    quot_o,
  output logic [DW-1:0]    rem_o
);

  logic [DW-1:0] rem_q  [QB];
  logic [QB-1:0] low_q  [QB];
  logic [QB-1:0] quot_q [QB];
  logic [DW-1:0] den_q  [QB];

  logic [DW-1:0] rem_in  [QB];
  logic [QB-1:0] low_in  [QB];
  logic [QB-1:0] quot_in [QB];
  logic [DW-1:0] den_in  [QB];
  logic [DW:0]   trial   [QB];
  logic          ge      [QB];
  logic [DW-1:0] rem_d   [QB];
  logic [QB-1:0] low_d   [QB];
  logic [QB-1:0] quot_d  [QB];

  // The upper part of the numerator is below the divisor, so it seeds the remainder.
  always_comb begin
    rem_in[0]  = num_i[QB+DW-1:QB];
    low_in[0]  = num_i[QB-1:0];
    quot_in[0] = '0;
    den_in[0]  = den_i;
    for (int i = 1; i < QB; i++) begin
      rem_in[i]  = rem_q[i-1];
      low_in[i]  = low_q[i-1];
      quot_in[i] = quot_q[i-1];
      den_in[i]  = den_q[i-1];
    end
    for (int i = 0; i < QB; i++) begin
      trial[i]  = {rem_in[i], low_in[i][QB-1]};
      ge[i]     = trial[i] >= {1'b0, den_in[i]};
      rem_d[i]  = ge[i] ? DW'(trial[i] - {1'b0, den_in[i]}) : DW'(trial[i]);
      low_d[i]  = low_in[i] << 1;
      quot_d[i] = {quot_in[i][QB-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < QB; i++) begin
        rem_q[i]  <= rem_d[i];
        low_q[i]  <= low_d[i];
        quot_q[i] <= quot_d[i];
        den_q[i]  <= den_in[i];
      end
    end
  end

  assign quot_o = quot_q[QB-1];
  assign rem_o  = rem_q[QB-1];

endmodule

/* sv/awsg_delay.sv */
// Enabled shift line that carries control and side data alongside the dividers.
// No dependencies.
module awsg_delay #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] line_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) line_q[i] <= '0;
    end else if (en_i) begin
      line_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) line_q[i] <= line_q[i-1];
    end
  end

  assign q_o = line_q[DEPTH-1];

endmodule

/* sv/awsg_sqrt_rom.sv */
// Quarter-circle ROM, sqrt(1-(k/P)^2) in Q1.16, read at k and k+1 with registered data.
// Depends on awsg_pkg for the entry width.
module awsg_sqrt_rom #(
  parameter int unsigned TABLE_POINTS = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic [$clog2(TABLE_POINTS+1)-1:0]      k_i,
  output logic [awsg_pkg::ROM_W-1:0]             t0_o,
  output logic [awsg_pkg::ROM_W-1:0]             t1_o
);
  import awsg_pkg::*;

  localparam int unsigned RA_W = $clog2(TABLE_POINTS+1);

  typedef logic [ROM_W-1:0] rom_t [TABLE_POINTS+1];

  function automatic rom_t build_rom();
    rom_t tab;
    longint unsigned pp, num, rem, v, res, bv;
    pp = 64'(TABLE_POINTS) * 64'(TABLE_POINTS);
    for (int k = 0; k <= TABLE_POINTS; k++) begin
      num = (pp - 64'(k) * 64'(k)) << 32;
      // Long division by the squared table size, one quotient bit per step.
      rem = 64'd0;
      v   = 64'd0;
      for (int i = 63; i >= 0; i--) begin
        rem = (rem << 1) | 64'(num[i]);
        v   = v << 1;
        if (rem >= pp) begin
          rem = rem - pp;
          v   = v | 64'd1;
        end
      end
      res = 64'd0;
      bv  = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
        if (v >= res + bv) begin
          v   = v - (res + bv);
          res = (res >> 1) + bv;
        end else begin
          res = res >> 1;
        end
        bv = bv >> 2;
      end
      tab[k] = ROM_W'(res);
    end
    return tab;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [RA_W-1:0]  k1;
  logic [ROM_W-1:0] t0_q, t1_q;

  assign k1 = k_i + RA_W'(1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t0_q <= ROM[k_i];
      t1_q <= ROM[k1];
    end
  end

  assign t0_o = t0_q;
  assign t1_o = t1_q;

endmodule

/* sv/awsg_out_fifo.sv */
// Four-entry span buffer: takes up to two spans a cycle, hands out one.
// Depends on awsg_pkg for the span type and depth constants.
module awsg_out_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push0_i,
  input  logic            push1_i,
  input  awsg_pkg::span_t span0_i,
  input  awsg_pkg::span_t span1_i,
  input  logic            pop_i,
  output logic            valid_o,
  output awsg_pkg::span_t head_o,
  output logic            room_o
);
  import awsg_pkg::*;

  span_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  pop;

  assign pop = pop_i && (cnt_q != '0);

  always_comb begin
    wr_d  = wr_q + FIFO_PTR_W'(push0_i) + FIFO_PTR_W'(push1_i);
    rd_d  = rd_q + FIFO_PTR_W'(pop);
    cnt_d = cnt_q + FIFO_CNT_W'(push0_i) + FIFO_CNT_W'(push1_i) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) mem_q[wr_q] <= span0_i;
    if (push1_i) mem_q[wr_q + FIFO_PTR_W'(1)] <= span1_i;
  end

  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  // Room for a whole request's spans, whatever leaves this cycle.
  assign room_o  = cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);

endmodule

/* sv/annulus_wedge_span_generator_top.sv */
// Top level of the annulus wedge span generator: scanline requests in, spans out.
// Depends on awsg_pkg, awsg_div_pipe, awsg_delay, awsg_sqrt_rom and awsg_out_fifo.
//
// One scanline request enters per clock while the output buffer has room. The dividers
// have DQ = max(log2(TABLE_POINTS) + 16, 27) bit-per-stage stages. Each request yields
// up to two spans through a four-span output buffer that hands out one span per clock
// while out_ready_i is high, so a run of requests that each produce two spans is held
// back by that buffer; that buffer's room alone drives in_ready_o. The user must write
// center_x and center_y over the APB port only while no request is in flight; the
// block itself does not enforce this.
module annulus_wedge_span_generator_top #(
  parameter int unsigned TABLE_POINTS = awsg_pkg::DEF_TABLE_POINTS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [awsg_pkg::ROW_W-1:0]   row_offset_i,
  input  logic [awsg_pkg::RAD_W-1:0]          inner_radius_i,
  input  logic [awsg_pkg::RAD_W-1:0]          outer_radius_i,
  input  logic                                wedge_on_i,
  input  logic signed [awsg_pkg::RAY_W-1:0]   ray1_sin_i,
  input  logic signed [awsg_pkg::RAY_W-1:0]   ray1_cos_i,
  input  logic signed [awsg_pkg::RAY_W-1:0]   ray2_sin_i,
  input  logic signed [awsg_pkg::RAY_W-1:0]   ray2_cos_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [awsg_pkg::XS_W-1:0]    x_start_o,
  output logic signed [awsg_pkg::SROW_W-1:0]  screen_row_o,
  output logic [awsg_pkg::SPW_W-1:0]          span_width_o,
  output logic                                last_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [awsg_pkg::APB_AW-1:0]         paddr,
  input  logic [awsg_pkg::APB_DW-1:0]         pwdata,
  output logic [awsg_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);
  import awsg_pkg::*;

  localparam int unsigned PW     = $clog2(TABLE_POINTS+1);
  localparam int unsigned KW     = $clog2(TABLE_POINTS);
  localparam int unsigned QW     = KW + FRAC_W;
  localparam int unsigned DQ     = (QW > RAY_QB) ? QW : RAY_QB;
  localparam int unsigned HNUM_W = DQ + RAD_W;
  localparam int unsigned RNUM_W = DQ + RAY_W;
  localparam int unsigned AP_W   = A_W + PW;
  localparam int unsigned SIDE_W = $bits(side_t);

  logic en;

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] center_x_q, center_y_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_CENTER_X: center_x_q <= pwdata[CFG_W-1:0];
        REG_CENTER_Y: center_y_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CENTER_X: prdata = APB_DW'(center_x_q);
      REG_CENTER_Y: prdata = APB_DW'(center_y_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------- stage 0: capture, magnitudes ----------------
  logic signed [12:0] m_in;
  logic               v0_q;
  logic signed [ROW_W-1:0] y0_q;
  logic [A_W-1:0]     a0_q;
  logic               mneg0_q;
  logic [RAD_W-1:0]   rin0_q, rout0_q;
  logic               wedge0_q;
  logic [RAY_W-1:0]   as0_q [2];
  logic [RAY_W-1:0]   ac0_q [2];
  logic               sneg0_q [2], szero0_q [2], cneg0_q [2], czero0_q [2];

  assign m_in = {row_offset_i, 4'b1000};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      y0_q      <= row_offset_i;
      a0_q      <= row_offset_i[ROW_W-1] ? A_W'(-m_in) : A_W'(m_in);
      mneg0_q   <= row_offset_i[ROW_W-1];
      rin0_q    <= inner_radius_i;
      rout0_q   <= outer_radius_i;
      wedge0_q  <= wedge_on_i;
      as0_q[0]  <= mag16(ray1_sin_i);
      as0_q[1]  <= mag16(ray2_sin_i);
      ac0_q[0]  <= mag16(ray1_cos_i);
      ac0_q[1]  <= mag16(ray2_cos_i);
      sneg0_q[0]  <= ray1_sin_i[RAY_W-1];
      sneg0_q[1]  <= ray2_sin_i[RAY_W-1];
      szero0_q[0] <= ray1_sin_i == '0;
      szero0_q[1] <= ray2_sin_i == '0;
      cneg0_q[0]  <= ray1_cos_i[RAY_W-1];
      cneg0_q[1]  <= ray2_cos_i[RAY_W-1];
      czero0_q[0] <= ray1_cos_i == '0;
      czero0_q[1] <= ray2_cos_i == '0;
    end
  end

  // ---------------- stage 1: products and flags ----------------
  logic [AP_W-1:0]     ap;
  logic [PROD_W-1:0]   prod [2];
  ray_side_t           rs [2];
  side_t               side1_d, side1_q;
  logic                v1_q;
  logic [HNUM_W-1:0]   hnum_out_q, hnum_in_q;
  logic [RNUM_W-1:0]   rnum_q [2];
  logic [RAY_W-1:0]    rden_q [2];

  always_comb begin
    ap = AP_W'(a0_q) * AP_W'(TABLE_POINTS);
    for (int j = 0; j < 2; j++) begin
      prod[j]     = PROD_W'(a0_q) * PROD_W'(ac0_q[j]);
      rs[j].neg   = !czero0_q[j] && (mneg0_q ^ cneg0_q[j] ^ sneg0_q[j]);
      rs[j].szero = szero0_q[j];
      rs[j].rejz  = szero0_q[j] && !czero0_q[j] && (mneg0_q ^ cneg0_q[j]);
    end
    // Ray one bounds from above for a positive sine, ray two for a negative one.
    rs[0].upper = !sneg0_q[0];
    rs[1].upper = sneg0_q[1];
    side1_d.y     = y0_q;
    side1_d.rin   = rin0_q;
    side1_d.rout  = rout0_q;
    side1_d.zout  = (rout0_q == '0) || (a0_q >= rout0_q);
    side1_d.zin   = (rin0_q == '0) || (a0_q >= rin0_q);
    side1_d.inner = a0_q < rin0_q;
    side1_d.wedge = wedge0_q;
    side1_d.r1    = rs[0];
    side1_d.r2    = rs[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= v0_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q    <= side1_d;
      hnum_out_q <= HNUM_W'({ap, {FRAC_W{1'b0}}});
      hnum_in_q  <= HNUM_W'({ap, {FRAC_W{1'b0}}});
      for (int j = 0; j < 2; j++) begin
        rnum_q[j] <= RNUM_W'(prod[j]);
        rden_q[j] <= as0_q[j];
      end
    end
  end

  // ---------------- divider stages ----------------
  logic [DQ-1:0]     hq_out, hq_in;
  logic [RAD_W-1:0]  hr_out, hr_in;
  logic [DQ-1:0]     rq [2];
  logic [RAY_W-1:0]  rr [2];
  logic              vd;
  side_t             sided;

  awsg_div_pipe #(.DW(RAD_W), .QB(DQ)) u_div_out (
    .clk_i(clk_i), .en_i(en), .num_i(hnum_out_q), .den_i(side1_q.rout),
    .quot_o(hq_out), .rem_o(hr_out)
  );

  awsg_div_pipe #(.DW(RAD_W), .QB(DQ)) u_div_in (
    .clk_i(clk_i), .en_i(en), .num_i(hnum_in_q), .den_i(side1_q.rin),
    .quot_o(hq_in), .rem_o(hr_in)
  );

  for (genvar j = 0; j < 2; j++) begin : g_ray_div
    awsg_div_pipe #(.DW(RAY_W), .QB(DQ)) u_div_ray (
      .clk_i(clk_i), .en_i(en), .num_i(rnum_q[j]), .den_i(rden_q[j]),
      .quot_o(rq[j]), .rem_o(rr[j])
    );
  end

  awsg_delay #(.W(SIDE_W + 1), .DEPTH(DQ)) u_side_dly (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
    .d_i({v1_q, side1_q}), .q_o({vd, sided})
  );

  // ---------------- E1: ROM read, floored ray bounds ----------------
  logic [ROM_W-1:0]          t0o, t1o, t0i, t1i;
  logic signed [BOUND_W-1:0] b_d [2];
  logic                      neg_d [2];
  logic                      v_e1_q;
  side_t                     side_e1_q;
  logic [FRAC_W-1:0]         fo_e1_q, fi_e1_q;
  logic signed [BOUND_W-1:0] b_e1_q [2];

  // The half-width remainders are not needed; the interpolation fraction carries on.
  logic unused_rem;
  assign unused_rem = ^{hr_out, hr_in};

  awsg_sqrt_rom #(.TABLE_POINTS(TABLE_POINTS)) u_rom_out (
    .clk_i(clk_i), .en_i(en), .k_i(PW'(hq_out[QW-1:FRAC_W])), .t0_o(t0o), .t1_o(t1o)
  );

  awsg_sqrt_rom #(.TABLE_POINTS(TABLE_POINTS)) u_rom_in (
    .clk_i(clk_i), .en_i(en), .k_i(PW'(hq_in[QW-1:FRAC_W])), .t0_o(t0i), .t1_o(t1i)
  );

  always_comb begin
    neg_d[0] = sided.r1.neg;
    neg_d[1] = sided.r2.neg;
    for (int j = 0; j < 2; j++) begin
      b_d[j] = neg_d[j]
             ? BOUND_W'(-(BOUND_W'(rq[j]) + BOUND_W'(rr[j] != '0)))
             : BOUND_W'(rq[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_e1_q <= 1'b0;
    else if (en) v_e1_q <= vd;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_e1_q <= sided;
      fo_e1_q   <= hq_out[FRAC_W-1:0];
      fi_e1_q   <= hq_in[FRAC_W-1:0];
      b_e1_q[0] <= b_d[0];
      b_e1_q[1] <= b_d[1];
    end
  end

  // ---------------- E2: interpolation product, wedge bounds ----------------
  logic [2*ROM_W-2:0]        dpo, dpi;
  logic                      hi_on_d, lo_on_d;
  logic signed [BOUND_W-1:0] hi_d, lo_d;
  logic                      act [2], up [2];
  logic                      v_e2_q;
  side_t                     side_e2_q;
  logic [ROM_W-1:0]          t0o_e2_q, t0i_e2_q, dpo_e2_q, dpi_e2_q;
  logic                      hi_on_e2_q, lo_on_e2_q, rej_e2_q;
  logic signed [BOUND_W-1:0] hi_e2_q, lo_e2_q;

  always_comb begin
    dpo = (2*ROM_W-1)'(t0o - t1o) * (2*ROM_W-1)'(fo_e1_q);
    dpi = (2*ROM_W-1)'(t0i - t1i) * (2*ROM_W-1)'(fi_e1_q);
    act[0] = side_e1_q.wedge && !side_e1_q.r1.szero;
    act[1] = side_e1_q.wedge && !side_e1_q.r2.szero;
    up[0]  = side_e1_q.r1.upper;
    up[1]  = side_e1_q.r2.upper;
    hi_on_d = 1'b0;
    lo_on_d = 1'b0;
    hi_d    = '0;
    lo_d    = '0;
    for (int j = 0; j < 2; j++) begin
      if (act[j]) begin
        if (up[j]) begin
          if (!hi_on_d || (b_e1_q[j] < hi_d)) hi_d = b_e1_q[j];
          hi_on_d = 1'b1;
        end else begin
          if (!lo_on_d || (b_e1_q[j] > lo_d)) lo_d = b_e1_q[j];
          lo_on_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_e2_q <= 1'b0;
    else if (en) v_e2_q <= v_e1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_e2_q  <= side_e1_q;
      t0o_e2_q   <= t0o;
      t0i_e2_q   <= t0i;
      dpo_e2_q   <= dpo[2*ROM_W-2:FRAC_W];
      dpi_e2_q   <= dpi[2*ROM_W-2:FRAC_W];
      hi_on_e2_q <= hi_on_d;
      lo_on_e2_q <= lo_on_d;
      hi_e2_q    <= hi_d;
      lo_e2_q    <= lo_d;
      rej_e2_q   <= side_e1_q.wedge && (side_e1_q.r1.rejz || side_e1_q.r2.rejz);
    end
  end

  // ---------------- E3: scale by radius, empty-wedge test ----------------
  logic [ROM_W-1:0]          wo, wi;
  logic [RAD_W+ROM_W-1:0]    wro, wri;
  logic                      v_e3_q;
  logic [HW_W-1:0]           wout_e3_q, win_e3_q;
  logic                      inner_e3_q, drop_e3_q, hi_on_e3_q, lo_on_e3_q;
  logic signed [BOUND_W-1:0] hi_e3_q, lo_e3_q;
  logic signed [ROW_W-1:0]   y_e3_q;

  always_comb begin
    wo  = t0o_e2_q - dpo_e2_q;
    wi  = t0i_e2_q - dpi_e2_q;
    wro = (RAD_W+ROM_W)'(wo) * (RAD_W+ROM_W)'(side_e2_q.rout);
    wri = (RAD_W+ROM_W)'(wi) * (RAD_W+ROM_W)'(side_e2_q.rin);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_e3_q <= 1'b0;
    else if (en) v_e3_q <= v_e2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wout_e3_q  <= side_e2_q.zout ? '0 : wro[FRAC_W+HW_W-1:FRAC_W];
      win_e3_q   <= side_e2_q.zin ? '0 : wri[FRAC_W+HW_W-1:FRAC_W];
      inner_e3_q <= side_e2_q.inner;
      drop_e3_q  <= rej_e2_q || (hi_on_e2_q && lo_on_e2_q && (hi_e2_q <= lo_e2_q));
      hi_on_e3_q <= hi_on_e2_q;
      lo_on_e3_q <= lo_on_e2_q;
      hi_e3_q    <= hi_e2_q;
      lo_e3_q    <= lo_e2_q;
      y_e3_q     <= side_e2_q.y;
    end
  end

  // ---------------- E4: clip the strips to the wedge ----------------
  logic signed [BOUND_W-1:0] wo_s, wi_s;
  logic signed [BOUND_W-1:0] sa [2], sb [2], l_d [2], h_d [2];
  logic                      v_e4_q, keep0_e4_q, keep1_e4_q;
  logic signed [BOUND_W-1:0] l_e4_q [2], h_e4_q [2];
  logic signed [ROW_W-1:0]   y_e4_q;

  always_comb begin
    wo_s  = $signed({{(BOUND_W-HW_W){1'b0}}, wout_e3_q});
    wi_s  = $signed({{(BOUND_W-HW_W){1'b0}}, win_e3_q});
    sa[0] = -wo_s;
    sb[0] = inner_e3_q ? -wi_s : wo_s;
    sa[1] = wi_s;
    sb[1] = wo_s;
    for (int j = 0; j < 2; j++) begin
      l_d[j] = (lo_on_e3_q && (lo_e3_q > sa[j])) ? lo_e3_q : sa[j];
      h_d[j] = (hi_on_e3_q && (hi_e3_q < sb[j])) ? hi_e3_q : sb[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_e4_q <= 1'b0;
    else if (en) v_e4_q <= v_e3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      keep0_e4_q <= !drop_e3_q && (wout_e3_q != '0);
      keep1_e4_q <= !drop_e3_q && (wout_e3_q != '0) && inner_e3_q;
      l_e4_q[0]  <= l_d[0];
      l_e4_q[1]  <= l_d[1];
      h_e4_q[0]  <= h_d[0];
      h_e4_q[1]  <= h_d[1];
      y_e4_q     <= y_e3_q;
    end
  end

  // ---------------- E5: widths, absolute placement, ordering ----------------
  logic  ok [2];
  span_t sp [2];
  logic  push0_e5_q, push1_e5_q;
  span_t first_e5_q, second_e5_q;
  span_t first_d;
  logic signed [SROW_W-1:0] row_d;

  always_comb begin
    row_d = SROW_W'($signed({2'b00, center_y_q}) + y_e4_q);
    ok[0] = v_e4_q && keep0_e4_q && (h_e4_q[0] > l_e4_q[0]);
    ok[1] = v_e4_q && keep1_e4_q && (h_e4_q[1] > l_e4_q[1]);
    for (int j = 0; j < 2; j++) begin
      sp[j].x_start    = XS_W'($signed({1'b0, center_x_q, 4'b0000}) + l_e4_q[j]);
      sp[j].screen_row = row_d;
      sp[j].span_width = SPW_W'(h_e4_q[j] - l_e4_q[j]);
      sp[j].last       = 1'b1;
    end
    // With both strips present the left one goes first and is not the last.
    first_d      = ok[0] ? sp[0] : sp[1];
    first_d.last = !(ok[0] && ok[1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push0_e5_q <= 1'b0;
      push1_e5_q <= 1'b0;
    end else if (en) begin
      push0_e5_q <= ok[0] || ok[1];
      push1_e5_q <= ok[0] && ok[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      first_e5_q  <= first_d;
      second_e5_q <= sp[1];
    end
  end

  // ---------------- output buffer ----------------
  span_t head;

  awsg_out_fifo u_fifo (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push0_i(en && push0_e5_q), .push1_i(en && push1_e5_q),
    .span0_i(first_e5_q), .span1_i(second_e5_q),
    .pop_i(out_ready_i), .valid_o(out_valid_o), .head_o(head), .room_o(en)
  );

  assign in_ready_o   = en;
  assign x_start_o    = head.x_start;
  assign screen_row_o = head.screen_row;
  assign span_width_o = head.span_width;
  assign last_o       = head.last;

endmodule

/* tb/tb_annulus_wedge_span_generator_top.sv */
// Self-checking testbench for the annulus wedge span generator top level.
// Depends on awsg_pkg and the block's RTL; predicts every span internally.
`timescale 1ns / 100ps

module tb_annulus_wedge_span_generator_top;
  import awsg_pkg::*;

  localparam int unsigned PTS       = DEF_TABLE_POINTS;
  localparam int          WDOG_MAX  = 20000;
  localparam int          DRAIN_CYC = 80;
  localparam int          N_RANDOM  = 1950;

  typedef struct {
    logic signed [ROW_W-1:0] row;
    logic [RAD_W-1:0]        rin;
    logic [RAD_W-1:0]        rout;
    logic                    wedge;
    logic signed [RAY_W-1:0] s1;
    logic signed [RAY_W-1:0] c1;
    logic signed [RAY_W-1:0] s2;
    logic signed [RAY_W-1:0] c2;
  } request_t;

  // Directed row: a request plus an optional hand-typed span count.
  typedef struct {
    request_t req;
    int       nspan;  // -1 means predictor only
  } vector_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o;
  logic signed [ROW_W-1:0] row_offset_i;
  logic [RAD_W-1:0] inner_radius_i, outer_radius_i;
  logic wedge_on_i;
  logic signed [RAY_W-1:0] ray1_sin_i, ray1_cos_i, ray2_sin_i, ray2_cos_i;
  logic out_valid_o, out_ready_i;
  logic signed [XS_W-1:0] x_start_o;
  logic signed [SROW_W-1:0] screen_row_o;
  logic [SPW_W-1:0] span_width_o;
  logic last_o;
  logic psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;

  annulus_wedge_span_generator_top i_dut (.*);

  span_t  span_queue[$];
  logic [CFG_W-1:0] centre_x, centre_y;
  longint sqrt_rom[PTS+1];
  int     n_errors, n_mismatch, n_spans, n_requests, watchdog;
  bit     stall_enable;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint circle_half(longint a, longint r);
    longint q, k, f, t0, t1, w;
    if (r <= 0 || a >= r) return 0;
    q = (a * PTS * 65536) / r;
    k = q >>> 16;
    f = q & 16'hFFFF;
    if (k >= PTS) return 0;
    t0 = sqrt_rom[k];
    t1 = sqrt_rom[k+1];
    w = t0 - (((t0 - t1) * f) >>> 16);
    return (w * r) >>> 16;
  endfunction

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0))) q--;
    return q;
  endfunction

  // Returns 0 when the ray rejects the row; a ray with a nonzero sine tightens lo or hi.
  function automatic bit clip_ray(longint m, longint s, longint c, bit upper_pos,
                                  inout longint lo, inout longint hi);
    longint b;
    if (s == 0) return !(m * c < 0);
    b = floor_quot(m * c, s);
    if ((s > 0) == upper_pos) begin
      if (b < hi) hi = b;
    end else begin
      if (b > lo) lo = b;
    end
    return 1;
  endfunction

  function automatic int predict_spans(request_t r);
    longint m, a, wout, win, lo, hi, sa[2], sb[2], l, h;
    int nseg, n;
    bit inner;
    span_t sp;
    m = 16 * longint'(r.row) + 8;
    a = m < 0 ? -m : m;
    lo = -(64'sd1 <<< 40);
    hi = 64'sd1 <<< 40;
    win = 0;
    n = 0;
    wout = circle_half(a, longint'(r.rout));
    if (wout <= 0) return 0;
    inner = a < longint'(r.rin);
    if (inner) win = circle_half(a, longint'(r.rin));
    if (r.wedge) begin
      if (!clip_ray(m, longint'(r.s1), longint'(r.c1), 1'b1, lo, hi)) return 0;
      if (!clip_ray(m, longint'(r.s2), longint'(r.c2), 1'b0, lo, hi)) return 0;
      if (hi <= lo) return 0;
    end
    if (inner) begin
      sa[0] = -wout; sb[0] = -win; sa[1] = win; sb[1] = wout; nseg = 2;
    end else begin
      sa[0] = -wout; sb[0] = wout; nseg = 1;
    end
    for (int k = 0; k < nseg; k++) begin
      l = sa[k] > lo ? sa[k] : lo;
      h = sb[k] < hi ? sb[k] : hi;
      if (h > l) begin
        sp.x_start    = XS_W'(longint'(centre_x) * 16 + l);
        sp.screen_row = SROW_W'(longint'(centre_y) + longint'(r.row));
        sp.span_width = SPW_W'(h - l);
        sp.last       = 1'b0;
        span_queue.push_back(sp);
        n++;
      end
    end
    if (n > 0) span_queue[$].last = 1'b1;
    return n;
  endfunction

  task automatic cycles(int n);
    repeat (n) @(posedge clk_i);
  endtask

  task automatic reg_write(logic reg_sel, logic [CFG_W-1:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00}; pwdata <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (reg_sel == REG_CENTER_X) centre_x = value;
    else centre_y = value;
  endtask

  // Valid stays high after acceptance so that requests can follow back to back;
  // it drops only for an idle burst or when the stream ends.
  task automatic send_request(request_t r, bit allow_gap);
    if (allow_gap && stall_enable && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      cycles($urandom_range(1, 9));
    end
    in_valid_i <= 1'b1;
    row_offset_i <= r.row; inner_radius_i <= r.rin; outer_radius_i <= r.rout;
    wedge_on_i <= r.wedge;
    ray1_sin_i <= r.s1; ray1_cos_i <= r.c1; ray2_sin_i <= r.s2; ray2_cos_i <= r.c2;
    do @(posedge clk_i); while (!in_ready_o);
    void'(predict_spans(r));
    n_requests++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (span_queue.size() != 0) @(posedge clk_i);
    cycles(DRAIN_CYC);
  endtask

  function automatic logic signed [RAY_W-1:0] rand_ray();
    case ($urandom_range(0, 5))
      0: return RAY_W'($urandom);
      1: return 16'sd0;
      2: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      default: return RAY_W'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic request_t rand_request();
    request_t r;
    r.rout  = $urandom_range(0, 9) == 0 ? RAD_W'($urandom) : RAD_W'($urandom_range(16, 1200));
    r.rin   = $urandom_range(0, 3) == 0 ? '0 : RAD_W'($urandom_range(0, r.rout + 64));
    if ($urandom_range(0, 9) == 0) r.rin = RAD_W'($urandom);
    // Keep most rows within the outer circle so spans are frequent.
    r.row   = $urandom_range(0, 7) == 0 ? ROW_W'($urandom) :
              ROW_W'($signed($urandom_range(0, 2 * (r.rout / 16) + 1)) -
                     $signed(r.rout / 16) - 1);
    r.wedge = $urandom_range(0, 1);
    r.s1 = rand_ray(); r.c1 = rand_ray(); r.s2 = rand_ray(); r.c2 = rand_ray();
    return r;
  endfunction

  // Output side: random stalls, compare against the oldest expected span.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        span_t exp_span;
        n_spans++;
        if (span_queue.size() == 0) begin
          n_errors++;
          if (n_mismatch++ < 10) $display("unexpected span x=%0d", x_start_o);
        end else begin
          exp_span = span_queue.pop_front();
          if (exp_span.x_start !== x_start_o || exp_span.screen_row !== screen_row_o ||
              exp_span.span_width !== span_width_o || exp_span.last !== last_o) begin
            n_errors++;
            if (n_mismatch++ < 10)
              $display("span mismatch: exp x=%0d row=%0d w=%0d l=%0b got x=%0d row=%0d w=%0d l=%0b",
                       exp_span.x_start, exp_span.screen_row, exp_span.span_width,
                       exp_span.last, x_start_o, screen_row_o, span_width_o, last_o);
          end
        end
      end
    end
  end

  int stall_left;
  always @(posedge clk_i) begin
    if (!stall_enable) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= stall_left == 1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 9);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WDOG_MAX) begin
      $display("watchdog expired, %0d spans outstanding", span_queue.size());
      $display("[annulus_wedge_span_generator_top] ERROR");
      $finish;
    end
  end

  initial begin
    vector_t vectors[$];
    request_t r;
    int got;
    for (int k = 0; k <= PTS; k++)
      sqrt_rom[k] = k >= PTS ? 0 : isqrt(((longint'(PTS * PTS) - k * k) << 32) / (PTS * PTS));
    n_errors = 0; n_mismatch = 0; n_spans = 0; n_requests = 0; watchdog = 0;
    stall_enable = 1'b0; stall_left = 0;
    centre_x = '0; centre_y = '0;
    rst_ni = 1'b0; in_valid_i = 1'b0; out_ready_i = 1'b1;
    row_offset_i = '0; inner_radius_i = '0; outer_radius_i = '0; wedge_on_i = 1'b0;
    ray1_sin_i = '0; ray1_cos_i = '0; ray2_sin_i = '0; ray2_cos_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cycles(3);
    rst_ni <= 1'b1;
    cycles(2);

    // Directed table: zero radius, row outside, disc, ring, wedge cases, extremes.
    vectors = '{
      '{'{9'sd0, 12'd0, 12'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 0},
      '{'{9'sd10, 12'd0, 12'd160, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 0},
      '{'{9'sd0, 12'd0, 12'd160, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1},
      '{'{9'sd0, 12'd80, 12'd160, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 2},
      '{'{9'sd0, 12'd300, 12'd160, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 0},
      '{'{-9'sd256, 12'd4095, 12'd4095, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 0},
      '{'{9'sd255, 12'd0, 12'd4095, 1'b0, -16'sd1, 16'sd1, 16'sd1, -16'sd1}, 1},
      '{'{-9'sd256, 12'd0, 12'd4095, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, -1},
      '{'{9'sd3, 12'd0, 12'd800, 1'b1, 16'sd0, -16'sd16384, 16'sd0, 16'sd0}, 0},
      '{'{9'sd3, 12'd0, 12'd800, 1'b1, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384}, 1},
      '{'{9'sd3, 12'd0, 12'd800, 1'b1, 16'sd11585, 16'sd11585, -16'sd11585, 16'sd11585}, -1},
      '{'{-9'sd4, 12'd200, 12'd800, 1'b1, -16'sd16384, 16'sd0, 16'sd16384, 16'sd0}, -1},
      '{'{9'sd2, 12'd0, 12'd800, 1'b1, -16'sd16384, 16'sd100, -16'sd16384, -16'sd100}, -1},
      '{'{9'sd2, 12'd100, 12'd800, 1'b1, 16'sd16384, -16'sd16384, -16'sd16384, 16'sd16384}, -1},
      '{'{-9'sd5, 12'd0, 12'd800, 1'b1, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768}, -1},
      '{'{9'sd1, 12'd4095, 12'd4095, 1'b1, 16'sd1, -16'sd1, -16'sd1, 16'sd1}, -1},
      '{'{9'sd0, 12'd50, 12'd200, 1'b0, -16'sd1, -16'sd1, -16'sd1, -16'sd1}, 2}
    };
    reg_write(REG_CENTER_X, 12'd0);
    reg_write(REG_CENTER_Y, 12'd0);
    foreach (vectors[i]) begin
      got = predict_spans(vectors[i].req);
      repeat (got) void'(span_queue.pop_back());
      if (vectors[i].nspan >= 0 && got != vectors[i].nspan) begin
        n_errors++;
        if (n_mismatch++ < 10)
          $display("directed row %0d: exp %0d spans, predicted %0d", i, vectors[i].nspan, got);
      end
      send_request(vectors[i].req, 1'b0);
    end
    wait_idle();
    reg_write(REG_CENTER_X, 12'd4095);
    reg_write(REG_CENTER_Y, 12'd4095);
    foreach (vectors[i]) send_request(vectors[i].req, 1'b0);
    wait_idle();

    // Random part in phases, each with its own centre setting.
    stall_enable = 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4) stall_enable = 1'b0;
      reg_write(REG_CENTER_X, ph == 1 ? 12'd4095 : ph == 2 ? 12'd0 : CFG_W'($urandom));
      reg_write(REG_CENTER_Y, ph == 1 ? 12'd0 : ph == 2 ? 12'd4095 : CFG_W'($urandom));
      for (int i = 0; i < N_RANDOM / 5; i++) begin
        r = rand_request();
        send_request(r, 1'b1);
      end
      wait_idle();
    end

    $display("Sent %0d scanline requests, checked %0d spans over several centre settings.",
             n_requests, n_spans);
    if (n_errors == 0 && span_queue.size() == 0) begin
      $display("[annulus_wedge_span_generator_top] OK");
    end else begin
      $display("%0d failures", n_errors + span_queue.size());
      $display("[annulus_wedge_span_generator_top] ERROR");
    end
    $finish;
  end

endmodule
